FILE: rtl/core/failed_attempt_limiter_unit_assert.svh
// Assertion macros for the failed-attempt limiter.
`ifndef FAILED_ATTEMPT_LIMITER_UNIT_ASSERT_SVH
`define FAILED_ATTEMPT_LIMITER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define FAL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("failed_attempt_limiter: assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define FAL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("failed_attempt_limiter: assertion failed");

`endif

FILE: rtl/core/fal_pkg.sv
// Shared types and constants of the failed-attempt limiter.
package fal_pkg;

  localparam int ENTRIES_DEF   = 64;
  localparam int KEY_BITS_DEF  = 64;
  localparam int TIME_BITS_DEF = 48;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;
  localparam int CNT_W     = 8;
  localparam int LEN_W     = 24;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  localparam logic [7:0]       THR_RST    = 8'd5;
  localparam logic [CFG_W-1:0] WINDOW_RST = 24'd300000;
  localparam logic [CFG_W-1:0] INIT_RST   = 24'd30000;
  localparam logic [CFG_W-1:0] CAP_RST    = 24'd900000;

  typedef enum logic [1:0] {
    ACT_CHECK     = 2'd0,
    ACT_FAIL      = 2'd1,
    ACT_CLEAR_KEY = 2'd2,
    ACT_CLEAR_ALL = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WINDOW    = 2'd1,
    CFG_INIT      = 2'd2,
    CFG_CAP       = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [7:0]       threshold;
    logic [CFG_W-1:0] window;
    logic [CFG_W-1:0] init_len;
    logic [CFG_W-1:0] cap_len;
  } cfg_t;

endpackage

FILE: rtl/core/fal_table.sv
// Record memory: one write port, one registered read port.
module fal_table #(
  parameter int DEPTH = fal_pkg::ENTRIES_DEF,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/fal_alu.sv
// Shared add/subtract unit with registered result and carry/borrow.
module fal_alu #(
  parameter int W = fal_pkg::TIME_BITS_DEF
) (
  input  logic             clk,
  input  fal_pkg::alu_op_t op,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [W-1:0]     res,
  output logic             carry
);

  logic [W:0] sum;

  always_comb begin
    if (op == fal_pkg::ALU_SUB) begin
      sum = {1'b0, a} - {1'b0, b};
    end else begin
      sum = {1'b0, a} + {1'b0, b};
    end
  end

  always_ff @(posedge clk) begin
    res   <= sum[W-1:0];
    carry <= sum[W];
  end

endmodule

FILE: rtl/core/fal_seq.sv
// Sequencer: table scan, allocation, failure update and reply.
module fal_seq #(
  parameter int ENTRIES   = fal_pkg::ENTRIES_DEF,
  parameter int KEY_BITS  = fal_pkg::KEY_BITS_DEF,
  parameter int TIME_BITS = fal_pkg::TIME_BITS_DEF,
  parameter int AW        = $clog2(ENTRIES),
  parameter int REC_W     = 1 + KEY_BITS + fal_pkg::CNT_W + 2 * TIME_BITS + fal_pkg::LEN_W
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fal_pkg::cfg_t                cfg,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [1:0]                   action,
  input  logic [63:0]                  key_tag,
  input  logic [47:0]                  now_ms,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output logic                         blocked,
  output logic                         table_full,
  output logic [fal_pkg::CNT_W-1:0]    fail_count,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [REC_W-1:0]             mem_wdata,
  output logic [AW-1:0]                mem_raddr,
  input  logic [REC_W-1:0]             mem_rdata,
  output fal_pkg::alu_op_t             alu_op,
  output logic [TIME_BITS-1:0]         alu_a,
  output logic [TIME_BITS-1:0]         alu_b,
  input  logic [TIME_BITS-1:0]         alu_res,
  input  logic                         alu_carry
);

  localparam int CW = fal_pkg::CNT_W;
  localparam int LW = fal_pkg::LEN_W;
  localparam int TB = TIME_BITS;
  localparam int KB = KEY_BITS;
  localparam int OFS_END   = LW;
  localparam int OFS_FIRST = LW + TB;
  localparam int OFS_CNT   = LW + 2 * TB;
  localparam int OFS_KEY   = LW + 2 * TB + CW;
  localparam int OFS_USED  = LW + 2 * TB + CW + KB;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_SCAN  = 12'b0000_0000_0100,
    S_ELAP  = 12'b0000_0000_1000,
    S_WIN   = 12'b0000_0001_0000,
    S_CAP   = 12'b0000_0010_0000,
    S_LEN   = 12'b0000_0100_0000,
    S_BEND  = 12'b0000_1000_0000,
    S_REM1  = 12'b0001_0000_0000,
    S_REM2  = 12'b0010_0000_0000,
    S_WRITE = 12'b0100_0000_0000,
    S_REPLY = 12'b1000_0000_0000
  } state_t;

  state_t          state;
  logic [AW-1:0]   rd_idx;
  logic [AW-1:0]   chk_idx;
  logic            chk_vld;
  logic            free_found;
  logic [AW-1:0]   free_idx;
  logic            clr_reply;

  fal_pkg::action_t act;
  logic [KB-1:0]   key;
  logic [TB-1:0]   now;
  logic [AW-1:0]   slot;

  logic            w_used;
  logic [KB-1:0]   w_key;
  logic [CW-1:0]   w_cnt;
  logic [TB-1:0]   w_first;
  logic [TB-1:0]   w_end;
  logic [LW-1:0]   w_len;
  logic [LW:0]     b0;
  logic            rem_nz;
  logic            res_blocked;
  logic            res_full;
  logic [CW-1:0]   res_count;

  logic            rd_used;
  logic [KB-1:0]   rd_key;
  logic            hit;
  logic            cur_free;
  logic            free_any;
  logic            chk_last;
  logic            accept;
  logic            rsp_free;
  logic            restart;
  logic [LW:0]     b0_next;
  logic [LW-1:0]   bsel;
  logic            thr_met;
  state_t          slot_state;

  assign rd_used  = mem_rdata[OFS_USED];
  assign rd_key   = mem_rdata[OFS_KEY +: KB];
  assign hit      = chk_vld && rd_used && (rd_key == key);
  assign cur_free = chk_vld && !rd_used;
  assign free_any = free_found || cur_free;
  assign chk_last = chk_vld && (chk_idx == LAST_IDX);
  assign accept   = (state == S_IDLE) && req_valid;
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign restart  = (w_cnt == '0) || alu_carry;
  assign b0_next  = (w_len != '0) ? {w_len, 1'b0} : {1'b0, cfg.init_len};
  assign bsel     = alu_carry ? cfg.cap_len : b0[LW-1:0];
  assign thr_met  = w_cnt >= cfg.threshold;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    unique case (act)
      fal_pkg::ACT_FAIL:      slot_state = S_ELAP;
      fal_pkg::ACT_CLEAR_KEY: slot_state = S_WRITE;
      default:                slot_state = S_REM1;
    endcase
  end

  always_comb begin
    alu_op = fal_pkg::ALU_SUB;
    alu_a  = now;
    alu_b  = w_first;
    unique case (state)
      S_WIN: begin
        alu_a = TB'(cfg.window);
        alu_b = alu_res;
      end
      S_CAP: begin
        alu_a = TB'(cfg.cap_len);
        alu_b = TB'(b0_next);
      end
      S_LEN: begin
        alu_op = fal_pkg::ALU_ADD;
        alu_b  = TB'(bsel);
      end
      S_REM1: begin
        alu_a = w_end;
        alu_b = now;
      end
      S_REM2: begin
        alu_a = TB'(w_len);
        alu_b = alu_res;
      end
      default: begin
      end
    endcase
  end

  assign mem_raddr = rd_idx;
  assign mem_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign mem_waddr = (state == S_CLEAR) ? rd_idx : slot;
  assign mem_wdata = ((state == S_CLEAR) || (act == fal_pkg::ACT_CLEAR_KEY)) ? '0 :
                     {w_used, w_key, w_cnt, w_first, w_end, w_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      rd_idx     <= '0;
      chk_vld    <= 1'b0;
      free_found <= 1'b0;
      clr_reply  <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if ((state == S_REPLY) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (rd_idx == LAST_IDX) begin
            rd_idx <= '0;
            state  <= clr_reply ? S_REPLY : S_IDLE;
          end else begin
            rd_idx <= rd_idx + AW'(1);
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            rd_idx     <= '0;
            chk_vld    <= 1'b0;
            free_found <= 1'b0;
            if (fal_pkg::action_t'(action) == fal_pkg::ACT_CLEAR_ALL) begin
              clr_reply <= 1'b1;
              state     <= S_CLEAR;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          chk_vld <= 1'b1;
          rd_idx  <= rd_idx + AW'(1);
          if (cur_free) begin
            free_found <= 1'b1;
          end
          if (hit) begin
            state <= slot_state;
          end else if (chk_last) begin
            state <= free_any ? slot_state : S_REPLY;
          end
        end
        S_ELAP:  state <= S_WIN;
        S_WIN:   state <= S_CAP;
        S_CAP:   state <= S_LEN;
        S_LEN:   state <= thr_met ? S_BEND : S_REM1;
        S_BEND:  state <= S_REM1;
        S_REM1:  state <= S_REM2;
        S_REM2:  state <= S_WRITE;
        S_WRITE: state <= S_REPLY;
        S_REPLY: begin
          if (rsp_free) begin
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    chk_idx <= rd_idx;
    if (accept) begin
      act         <= fal_pkg::action_t'(action);
      key         <= KB'(key_tag);
      now         <= TB'(now_ms);
      res_blocked <= 1'b0;
      res_full    <= 1'b0;
      res_count   <= '0;
    end
    if (state == S_SCAN) begin
      if (cur_free && !free_found) begin
        free_idx <= chk_idx;
      end
      if (hit) begin
        slot    <= chk_idx;
        w_used  <= rd_used;
        w_key   <= rd_key;
        w_cnt   <= mem_rdata[OFS_CNT +: CW];
        w_first <= mem_rdata[OFS_FIRST +: TB];
        w_end   <= mem_rdata[OFS_END +: TB];
        w_len   <= mem_rdata[LW-1:0];
      end else if (chk_last) begin
        slot    <= free_found ? free_idx : chk_idx;
        w_used  <= 1'b1;
        w_key   <= key;
        w_cnt   <= '0;
        w_first <= '0;
        w_end   <= '0;
        w_len   <= '0;
        res_full <= !free_any;
      end
    end
    if (state == S_CAP) begin
      b0 <= b0_next;
      if (restart) begin
        w_first <= now;
        w_cnt   <= CW'(1);
      end else if (w_cnt != fal_pkg::CNT_MAX) begin
        w_cnt <= w_cnt + CW'(1);
      end
    end
    if ((state == S_LEN) && thr_met) begin
      w_len <= bsel;
    end
    if (state == S_BEND) begin
      w_end <= alu_res;
    end
    if (state == S_REM2) begin
      rem_nz <= (alu_res != '0);
    end
    if (state == S_WRITE) begin
      res_blocked <= (act != fal_pkg::ACT_CLEAR_KEY) && rem_nz && !alu_carry;
      res_count   <= (act == fal_pkg::ACT_CLEAR_KEY) ? '0 : w_cnt;
    end
    if ((state == S_REPLY) && rsp_free) begin
      blocked    <= res_blocked;
      table_full <= res_full;
      fail_count <= res_count;
    end
  end

endmodule

FILE: rtl/core/failed_attempt_limiter_unit.sv
// Top level of the failed-attempt limiter.
//
// Request channel (req_valid/req_stall): action, key_tag, now_ms. Response
// channel (rsp_valid/rsp_stall): blocked, table_full, fail_count, one per
// request. cfg_wr_en writes cfg_wdata into the setting chosen by cfg_addr.
//
// One request at a time: req_stall is high from acceptance until the
// response is loaded into the output register. The record table is scanned
// one entry per cycle through its registered read port, then a shared
// add/subtract unit runs the update steps. A failure checks the window,
// grows the block length and sets its end once the threshold is met, then
// reckons the remaining block time as a check does; a key clear skips the
// unit. The sequencer returns to idle before the next request is taken.
// The next request is taken while a response waits under rsp_stall; a
// finished request waits only if the previous response is still held.
//
// After rst the table is swept to zero, one entry per cycle, with
// req_stall high; settings return to their defaults.
`include "failed_attempt_limiter_unit_assert.svh"

module failed_attempt_limiter_unit #(
  parameter int ENTRIES   = fal_pkg::ENTRIES_DEF,
  parameter int KEY_BITS  = fal_pkg::KEY_BITS_DEF,
  parameter int TIME_BITS = fal_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [fal_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [fal_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [1:0]                        action,
  input  logic [63:0]                       key_tag,
  input  logic [47:0]                       now_ms,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic                              blocked,
  output logic                              table_full,
  output logic [fal_pkg::CNT_W-1:0]         fail_count
);

  localparam int AW    = $clog2(ENTRIES);
  localparam int REC_W = 1 + KEY_BITS + fal_pkg::CNT_W + 2 * TIME_BITS + fal_pkg::LEN_W;

  fal_pkg::cfg_t       cfg;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [REC_W-1:0]    mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [REC_W-1:0]    mem_rdata;
  fal_pkg::alu_op_t    alu_op;
  logic [TIME_BITS-1:0] alu_a;
  logic [TIME_BITS-1:0] alu_b;
  logic [TIME_BITS-1:0] alu_res;
  logic                alu_carry;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= fal_pkg::THR_RST;
      cfg.window    <= fal_pkg::WINDOW_RST;
      cfg.init_len  <= fal_pkg::INIT_RST;
      cfg.cap_len   <= fal_pkg::CAP_RST;
    end else if (cfg_wr_en) begin
      unique case (fal_pkg::cfg_reg_t'(cfg_addr))
        fal_pkg::CFG_THRESHOLD: cfg.threshold <= cfg_wdata[7:0];
        fal_pkg::CFG_WINDOW:    cfg.window    <= cfg_wdata;
        fal_pkg::CFG_INIT:      cfg.init_len  <= cfg_wdata;
        fal_pkg::CFG_CAP:       cfg.cap_len   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  fal_table #(
    .DEPTH (ENTRIES),
    .WIDTH (REC_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fal_alu #(
    .W (TIME_BITS)
  ) u_alu (
    .clk   (clk),
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .res   (alu_res),
    .carry (alu_carry)
  );

  fal_seq #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .TIME_BITS (TIME_BITS),
    .AW        (AW),
    .REC_W     (REC_W)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .action     (action),
    .key_tag    (key_tag),
    .now_ms     (now_ms),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .blocked    (blocked),
    .table_full (table_full),
    .fail_count (fail_count),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .alu_op     (alu_op),
    .alu_a      (alu_a),
    .alu_b      (alu_b),
    .alu_res    (alu_res),
    .alu_carry  (alu_carry)
  );

  `FAL_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
  `FAL_ASSERT_NOW(a_full_is_empty, rsp_valid && table_full, !blocked && (fail_count == '0))
  `FAL_ASSERT_NOW(a_blocked_has_count, rsp_valid && blocked, fail_count != '0)
  `FAL_ASSERT_NOW(a_full_not_blocked, rsp_valid && blocked, !table_full)

endmodule

FILE: tb/failed_attempt_limiter_unit_test.sv
// Self-checking testbench for the failed-attempt limiter: table predictor, stalls, config phases.
`timescale 1ns / 100ps

module failed_attempt_limiter_unit_test;
  import fal_pkg::*;

  localparam int ENTRIES = ENTRIES_DEF;
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    action_t     act;
    logic [63:0] key;
    logic [47:0] stamp;
  } attempt_t;

  typedef struct packed {
    logic       blocked;
    logic       full;
    logic [7:0] count;
  } verdict_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en = 1'b0;
  cfg_reg_t         cfg_addr = CFG_THRESHOLD;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             req_valid = 1'b0;
  logic             req_stall;
  action_t          action = ACT_CHECK;
  logic [63:0]      key_tag = '0;
  logic [47:0]      now_ms = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  logic             blocked;
  logic             table_full;
  logic [CNT_W-1:0] fail_count;

  failed_attempt_limiter_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .action     (action),
    .key_tag    (key_tag),
    .now_ms     (now_ms),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .blocked    (blocked),
    .table_full (table_full),
    .fail_count (fail_count)
  );

  // Mirror of the settings and of the record table
  logic [7:0]  thr_cfg = THR_RST;
  logic [23:0] window_cfg = WINDOW_RST;
  logic [23:0] init_cfg = INIT_RST;
  logic [23:0] cap_cfg = CAP_RST;

  logic        rec_used  [ENTRIES];
  logic [63:0] rec_key   [ENTRIES];
  logic [7:0]  rec_count [ENTRIES];
  logic [47:0] rec_first [ENTRIES];
  logic [47:0] rec_end   [ENTRIES];
  logic [23:0] rec_len   [ENTRIES];

  attempt_t pending[$];
  verdict_t verdicts_due[$];

  int queued_n = 0;
  int accepted_n = 0;
  int checked_n = 0;
  int errors = 0;
  int quiet_n = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < ENTRIES; i++) wipe_record(i);
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), $urandom};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic void wipe_record(int i);
    rec_used[i]  = 1'b0;
    rec_key[i]   = '0;
    rec_count[i] = '0;
    rec_first[i] = '0;
    rec_end[i]   = '0;
    rec_len[i]   = '0;
  endfunction

  function automatic verdict_t predict_attempt(action_t act, logic [63:0] key,
                                               logic [47:0] stamp);
    verdict_t    res;
    int          slot;
    logic [47:0] elapsed;
    logic [47:0] remain;
    logic [24:0] next_len;
    res = '0;
    if (act == ACT_CLEAR_ALL) begin
      for (int i = 0; i < ENTRIES; i++) wipe_record(i);
      return res;
    end
    slot = -1;
    for (int i = 0; i < ENTRIES && slot < 0; i++)
      if (rec_used[i] && rec_key[i] == key) slot = i;
    if (slot < 0) begin
      for (int i = 0; i < ENTRIES && slot < 0; i++)
        if (!rec_used[i]) slot = i;
      if (slot < 0) begin
        res.full = 1'b1;
        return res;
      end
      wipe_record(slot);
      rec_used[slot] = 1'b1;
      rec_key[slot]  = key;
    end
    if (act == ACT_CLEAR_KEY) begin
      wipe_record(slot);
      return res;
    end
    if (act == ACT_FAIL) begin
      elapsed = stamp - rec_first[slot];
      if (rec_count[slot] == 0 || elapsed > {24'd0, window_cfg}) begin
        rec_count[slot] = '0;
        rec_first[slot] = stamp;
      end
      if (rec_count[slot] != CNT_MAX) rec_count[slot]++;
      if (rec_count[slot] >= thr_cfg) begin
        next_len = (rec_len[slot] != 0) ? {rec_len[slot], 1'b0} : {1'b0, init_cfg};
        if (next_len > {1'b0, cap_cfg}) next_len = {1'b0, cap_cfg};
        rec_len[slot] = next_len[23:0];
        rec_end[slot] = stamp + {24'd0, next_len[23:0]};
      end
    end
    remain = rec_end[slot] - stamp;
    res.blocked = (remain != 0) && (remain <= {24'd0, rec_len[slot]});
    res.count = rec_count[slot];
    return res;
  endfunction

  // Sender
  always @(posedge clk) begin : req_driver
    attempt_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        verdicts_due.push_back(predict_attempt(action, key_tag, now_ms));
        accepted_n++;
      end
      if (!req_valid || !req_stall) begin
        if (pending.size() != 0 &&
            ((accepted_n >= 600 && accepted_n < 800) || $urandom_range(0, 99) >= 30)) begin
          nxt = pending.pop_front();
          req_valid <= 1'b1;
          action    <= nxt.act;
          key_tag   <= nxt.key;
          now_ms    <= nxt.stamp;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker
  always @(posedge clk) begin : rsp_monitor
    verdict_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: result with nothing due: blocked %0b table_full %0b fail_count %0d",
                   $time, blocked, table_full, fail_count);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          checked_n++;
          if (blocked !== want.blocked) begin
            $display("%0t: blocked expected %0b got %0b", $time, want.blocked, blocked);
            errors++;
          end
          if (table_full !== want.full) begin
            $display("%0t: table_full expected %0b got %0b", $time, want.full, table_full);
            errors++;
          end
          if (fail_count !== want.count) begin
            $display("%0t: fail_count expected %0d got %0d", $time, want.count, fail_count);
            errors++;
          end
        end
      end
      // one long hold-off to back up the request side
      if (checked_n >= 150 && !hold_done) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !(checked_n >= 600 && checked_n < 800) && ($urandom_range(0, 99) < 30);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_n = 0;
    end else begin
      quiet_n++;
    end
    if (quiet_n >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_attempt(action_t act, logic [63:0] key, logic [47:0] stamp);
    attempt_t a;
    a.act = act;
    a.key = key;
    a.stamp = stamp;
    pending.push_back(a);
    queued_n++;
  endtask

  task automatic wait_drained();
    while (accepted_n != queued_n || checked_n != accepted_n) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_limits(logic [7:0] thr, logic [23:0] win, logic [23:0] init_len,
                            logic [23:0] cap);
    wait_drained();
    repeat (8) @(posedge clk);
    write_reg(CFG_THRESHOLD, {16'd0, thr});
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_INIT, init_len);
    write_reg(CFG_CAP, cap);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    thr_cfg = thr;
    window_cfg = win;
    init_cfg = init_len;
    cap_cfg = cap;
  endtask

  // clear_pml: per-mille of clears of both kinds (table clears at an eighth of that)
  task automatic random_phase(logic [7:0] thr, logic [23:0] win, logic [23:0] init_len,
                              logic [23:0] cap, int n, int pool_n, int hot_pct,
                              int fail_pml, int clear_pml, int noise_pct, int step_max,
                              logic [47:0] base);
    logic [63:0] pool [128];
    logic [63:0] key;
    logic [47:0] t;
    logic [47:0] stamp;
    action_t     act;
    int          r;
    set_limits(thr, win, init_len, cap);
    for (int i = 0; i < pool_n; i++) pool[i] = rand64();
    t = base;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 999);
      if (r < clear_pml / 8) act = ACT_CLEAR_ALL;
      else if (r < clear_pml) act = ACT_CLEAR_KEY;
      else if (r < clear_pml + fail_pml) act = ACT_FAIL;
      else act = ACT_CHECK;
      r = $urandom_range(0, 99);
      if (r < noise_pct) key = rand64();
      else if (r < noise_pct + hot_pct) key = pool[0];
      else key = pool[$urandom_range(0, pool_n - 1)];
      t = t + 48'($urandom_range(0, step_max));
      r = $urandom_range(0, 99);
      if (r < noise_pct) stamp = rand48();
      else if (r < 2 * noise_pct) stamp = t - 48'($urandom_range(0, step_max));
      else stamp = t;
      add_attempt(act, key, stamp);
    end
  endtask

  initial begin
    logic [63:0] k0;
    logic [63:0] kmax;
    k0 = 64'h0123_4567_89AB_CDEF;
    kmax = '1;

    // directed: runs with the reset settings
    add_attempt(ACT_CHECK, k0, 48'd0);          // check allocates
    for (int i = 1; i <= 5; i++) add_attempt(ACT_FAIL, k0, 48'(i));
    add_attempt(ACT_CHECK, k0, 48'd30004);      // last ms of the block
    add_attempt(ACT_CHECK, k0, 48'd30005);      // block just ended
    add_attempt(ACT_FAIL, k0, 48'd30006);       // doubled block
    add_attempt(ACT_CLEAR_KEY, k0, 48'd30007);
    add_attempt(ACT_CHECK, k0, 48'd30008);
    add_attempt(ACT_FAIL, kmax, '1);
    add_attempt(ACT_FAIL, 64'd0, 48'd0);
    add_attempt(ACT_FAIL, 64'd0, 48'd300000);   // elapsed equals window
    add_attempt(ACT_FAIL, 64'd0, 48'd600001);   // window restart
    add_attempt(ACT_CLEAR_KEY, 64'hDEAD_BEEF_0000_0001, 48'd7);
    add_attempt(ACT_FAIL, kmax, 48'd1);         // elapsed across the wrap
    add_attempt(ACT_CLEAR_ALL, rand64(), rand48());
    add_attempt(ACT_CHECK, kmax, 48'd5);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    random_phase(8'd5, 24'd300000, 24'd30000, 24'd900000, 250, 6, 30, 500, 40, 2,
                 20000, 48'hFFFF_FFF0_0000);
    random_phase(8'd1, 24'd1, 24'd1, 24'd1, 150, 6, 20, 500, 40, 2, 3, rand48());
    random_phase(8'd0, 24'd50, 24'd3, 24'hFF_FFFF, 200, 4, 20, 600, 20, 2, 40, 48'd0);
    random_phase(8'd255, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 330, 1, 100, 900, 0, 0,
                 20000, 48'hFFFF_FFFF_0000);
    random_phase(8'd3, 24'd500, 24'd5000, 24'd3000, 300, 90, 0, 500, 20, 2, 300, rand48());
    random_phase(8'd2, 24'd1000, 24'd100, 24'd800, 120, 8, 20, 500, 40, 5, 600, 48'd0);

    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
